// File: rtl/triaxial_sample_aligner_assert.svh
// ----------------------------------------------------------------------------
// Triaxial sample aligner assertion macros
// Concurrent checks on the rising edge of i_clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef TRIAXIAL_SAMPLE_ALIGNER_ASSERT_SVH
`define TRIAXIAL_SAMPLE_ALIGNER_ASSERT_SVH
`ifndef ASSERT_OFF
// consequent must hold in the same cycle as the antecedent
`define TSA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// consequent must hold in the cycle after the antecedent
`define TSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TSA_ASSERT_NOW(lbl, ante, cons, msg)
`define TSA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/tsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triaxial sample aligner package
// Field widths, axis and sequencer codes, and the channel code decoder.
// ----------------------------------------------------------------------------
package tsa_pkg;

    localparam int CODE_W   = 8;
    localparam int TIME_W   = 48;
    localparam int SMP_W    = 32;
    localparam int SEQ_W    = 32;
    localparam int TOL_W    = 24;
    localparam int TOL_FRAC = 8;
    localparam int NUM_AXES = 3;

    localparam logic [TOL_W-1:0] TOL_RESET = 24'd640;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_X,
        ST_RD_Y,
        ST_RD_Z,
        ST_CAPT,
        ST_MAX,
        ST_DECIDE
    } t_state;

    // map the last character of the channel code onto an axis
    function automatic t_axis axis_of(input logic [CODE_W-1:0] code);
        t_axis ax;
        case (code)
            "Z", "z", "3":           ax = AXIS_Z;
            "N", "n", "Y", "y", "2": ax = AXIS_Y;
            "E", "e", "X", "x", "1": ax = AXIS_X;
            default:                 ax = AXIS_NONE;
        endcase
        return ax;
    endfunction

endpackage

// File: rtl/tsa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triaxial sample aligner channels
// Valid/ready channels for samples in, aligned triples out and tolerance writes.
// ----------------------------------------------------------------------------
interface tsa_sample_if
    import tsa_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CODE_W-1:0]        channel_code;
    logic [TIME_W-1:0]        time_ms;
    logic signed [SMP_W-1:0]  sample;

    modport source (output valid, channel_code, time_ms, sample, input ready);
    modport sink   (input valid, channel_code, time_ms, sample, output ready);
endinterface

interface tsa_triple_if
    import tsa_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [TIME_W-1:0]        triple_time_ms;
    logic signed [SMP_W-1:0]  x_sample;
    logic signed [SMP_W-1:0]  y_sample;
    logic signed [SMP_W-1:0]  z_sample;
    logic [SEQ_W-1:0]         sequence_res;
    logic                     overflowed;

    modport source (output valid, triple_time_ms, x_sample, y_sample, z_sample,
                    sequence_res, overflowed, input ready);
    modport sink   (input valid, triple_time_ms, x_sample, y_sample, z_sample,
                    sequence_res, overflowed, output ready);
endinterface

interface tsa_cfg_if
    import tsa_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [TOL_W-1:0]  tolerance_q8;

    modport source (output valid, tolerance_q8, input ready);
    modport sink   (input valid, tolerance_q8, output ready);
endinterface

// File: rtl/triaxial_sample_aligner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triaxial sample aligner
// Sorts tagged samples into three per-axis queues held in one memory and
// emits time-aligned X/Y/Z triples, dropping stale heads on misalignment.
// ----------------------------------------------------------------------------
//  channel       dir  beat                                      notes
//  i_sample_ch   in   channel_code, time_ms, sample             ready only when idle
//  i_cfg_ch      in   tolerance_q8 (1/256 ms)                   always ready
//  o_triple_ch   out  time, x/y/z samples, sequence, overflow   registered output
//
//  A sample beat is taken while idle. When it leaves all three queues
//  non-empty, ready drops for alignment passes (three reads
//  of the entry memory, a capture slot, the maximum, the decision): one pass
//  per round of dropped heads plus one for the triple.
//  An emitting pass waits while the output register still holds an untaken beat.
//  Reset is synchronous and active low; queue contents need no clearing pass.
// ----------------------------------------------------------------------------
`include "triaxial_sample_aligner_assert.svh"

module triaxial_sample_aligner
    import tsa_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tsa_sample_if.sink    i_sample_ch,
    tsa_cfg_if.sink       i_cfg_ch,
    tsa_triple_if.source  o_triple_ch
);

    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W     = PTR_W + 1;
    localparam int MEM_DEPTH = NUM_AXES * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int ENTRY_W   = TIME_W + SMP_W;

    localparam logic [PTR_W-1:0]  LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0]  DEPTH_SUM = SUM_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] BASE_Y    = ADDR_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] BASE_Z    = ADDR_W'(2 * QUEUE_DEPTH);

    // entry address of slot p in the queue of axis ax
    function automatic logic [ADDR_W-1:0] entry_addr(input logic [1:0] ax,
                                                      input logic [PTR_W-1:0] p);
        logic [ADDR_W-1:0] base;
        case (ax)
            AXIS_Y:  base = BASE_Y;
            AXIS_Z:  base = BASE_Z;
            default: base = '0;
        endcase
        return base + ADDR_W'(p);
    endfunction

    // control state
    t_state             r_state, n_state;
    logic [TOL_W-1:0]   r_tol;
    logic [PTR_W-1:0]   r_head [NUM_AXES];
    logic [PTR_W-1:0]   n_head [NUM_AXES];
    logic [CNT_W-1:0]   r_fill [NUM_AXES];
    logic [CNT_W-1:0]   n_fill [NUM_AXES];
    logic [SEQ_W-1:0]   r_seq, n_seq;
    logic               r_ovf, n_ovf;

    // head snapshot for the alignment pass
    logic [TIME_W-1:0]  r_head_time [NUM_AXES];
    logic [SMP_W-1:0]   r_head_smp  [NUM_AXES];
    logic [TIME_W-1:0]  r_tmax;

    // entry memory
    logic [ENTRY_W-1:0] r_mem [MEM_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [ADDR_W-1:0]  w_raddr;

    // output register
    logic                    r_out_valid;
    logic [TIME_W-1:0]       r_out_time;
    logic signed [SMP_W-1:0] r_out_x;
    logic signed [SMP_W-1:0] r_out_y;
    logic signed [SMP_W-1:0] r_out_z;
    logic [SEQ_W-1:0]        r_out_seq;
    logic                    r_out_ovf;

    // decode and datapath helpers
    t_axis               w_axis;
    logic [1:0]          w_ax_idx;
    logic [SUM_W-1:0]    w_tail_sum;
    logic [PTR_W-1:0]    w_tail;
    logic [TIME_W-1:0]   w_thr;
    logic [NUM_AXES-1:0] w_drop;
    logic                w_load;
    logic                w_in_ready;
    logic [TIME_W-1:0]   w_max_xy;

    assign w_axis   = axis_of(i_sample_ch.channel_code);
    assign w_ax_idx = w_axis;

    // tail slot of the addressed queue, wrapped once
    always_comb begin
        w_tail_sum = SUM_W'(r_head[w_ax_idx]) + SUM_W'(r_fill[w_ax_idx]);
        if (w_tail_sum >= DEPTH_SUM) begin
            w_tail_sum = w_tail_sum - DEPTH_SUM;
        end
        w_tail = w_tail_sum[PTR_W-1:0];
    end

    // diff * 256 > tol is the same as diff > tol / 256
    assign w_thr = TIME_W'(r_tol[TOL_W-1:TOL_FRAC]);

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            w_drop[k] = (r_tmax - r_head_time[k]) > w_thr;
        end
    end

    assign w_max_xy = (r_head_time[1] > r_head_time[0]) ? r_head_time[1] : r_head_time[0];

    // sequencer: next state, queue bookkeeping and memory control
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_fill     = r_fill;
        n_seq      = r_seq;
        n_ovf      = r_ovf;
        w_we       = 1'b0;
        w_waddr    = entry_addr(w_ax_idx, w_tail);
        w_raddr    = '0;
        w_load     = 1'b0;
        w_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_sample_ch.valid) begin
                    if (w_axis != AXIS_NONE) begin
                        if (r_fill[w_ax_idx] == FULL_CNT) begin
                            n_ovf = 1'b1;
                        end else begin
                            w_we             = 1'b1;
                            n_fill[w_ax_idx] = r_fill[w_ax_idx] + CNT_W'(1);
                        end
                    end
                    if (n_fill[0] != '0 && n_fill[1] != '0 && n_fill[2] != '0) begin
                        n_state = ST_RD_X;
                    end
                end
            end
            ST_RD_X: begin
                w_raddr = entry_addr(AXIS_X, r_head[0]);
                n_state = ST_RD_Y;
            end
            ST_RD_Y: begin
                w_raddr = entry_addr(AXIS_Y, r_head[1]);
                n_state = ST_RD_Z;
            end
            ST_RD_Z: begin
                w_raddr = entry_addr(AXIS_Z, r_head[2]);
                n_state = ST_CAPT;
            end
            ST_CAPT: begin
                n_state = ST_MAX;
            end
            ST_MAX: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (w_drop != '0) begin
                    // drop stale heads and look again
                    for (int k = 0; k < NUM_AXES; k++) begin
                        if (w_drop[k]) begin
                            n_head[k] = (r_head[k] == LAST_PTR) ? '0 : r_head[k] + PTR_W'(1);
                            n_fill[k] = r_fill[k] - CNT_W'(1);
                        end
                    end
                    if (n_fill[0] != '0 && n_fill[1] != '0 && n_fill[2] != '0) begin
                        n_state = ST_RD_X;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (!r_out_valid || o_triple_ch.ready) begin
                    // emit the triple and pop all heads
                    w_load = 1'b1;
                    n_seq  = r_seq + SEQ_W'(1);
                    for (int k = 0; k < NUM_AXES; k++) begin
                        n_head[k] = (r_head[k] == LAST_PTR) ? '0 : r_head[k] + PTR_W'(1);
                        n_fill[k] = r_fill[k] - CNT_W'(1);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_seq   <= '0;
            r_ovf   <= 1'b0;
            for (int k = 0; k < NUM_AXES; k++) begin
                r_head[k] <= '0;
                r_fill[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_seq   <= n_seq;
            r_ovf   <= n_ovf;
        end
    end

    // tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_ch.valid) begin
            r_tol <= i_cfg_ch.tolerance_q8;
        end
    end

    // entry memory: one write and one read a cycle, read data registered
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= {i_sample_ch.time_ms, i_sample_ch.sample};
        end
        r_rd_data <= r_mem[w_raddr];
    end

    // capture each head in the state after its read, then take the newest time
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_RD_Y: begin
                r_head_time[0] <= r_rd_data[ENTRY_W-1:SMP_W];
                r_head_smp[0]  <= r_rd_data[SMP_W-1:0];
            end
            ST_RD_Z: begin
                r_head_time[1] <= r_rd_data[ENTRY_W-1:SMP_W];
                r_head_smp[1]  <= r_rd_data[SMP_W-1:0];
            end
            ST_CAPT: begin
                r_head_time[2] <= r_rd_data[ENTRY_W-1:SMP_W];
                r_head_smp[2]  <= r_rd_data[SMP_W-1:0];
            end
            ST_MAX: begin
                r_tmax <= (r_head_time[2] > w_max_xy) ? r_head_time[2] : w_max_xy;
            end
            default: begin
            end
        endcase
    end

    // output register: hold until the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_triple_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_time <= r_head_time[0];
            r_out_x    <= r_head_smp[0];
            r_out_y    <= r_head_smp[1];
            r_out_z    <= r_head_smp[2];
            r_out_seq  <= n_seq;
            r_out_ovf  <= r_ovf;
        end
    end

    // port drive
    assign i_sample_ch.ready          = w_in_ready;
    assign i_cfg_ch.ready             = 1'b1;
    assign o_triple_ch.valid          = r_out_valid;
    assign o_triple_ch.triple_time_ms = r_out_time;
    assign o_triple_ch.x_sample       = r_out_x;
    assign o_triple_ch.y_sample       = r_out_y;
    assign o_triple_ch.z_sample       = r_out_z;
    assign o_triple_ch.sequence_res   = r_out_seq;
    assign o_triple_ch.overflowed     = r_out_ovf;

    // checks
    `TSA_ASSERT_NOW(a_fill_bound, 1'b1, (r_fill[0] <= FULL_CNT) && (r_fill[1] <= FULL_CNT) && (r_fill[2] <= FULL_CNT), "queue fill beyond depth")
    `TSA_ASSERT_NOW(a_emit_needs_heads, w_load, (r_fill[0] != '0) && (r_fill[1] != '0) && (r_fill[2] != '0), "triple emitted from an empty queue")
    `TSA_ASSERT_NEXT(a_seq_step, w_load, r_out_seq == $past(r_seq) + SEQ_W'(1), "sequence number did not advance by one")
    `TSA_ASSERT_NEXT(a_drop_shrinks, (r_state == ST_DECIDE) && (w_drop != '0), (r_fill[0] < $past(r_fill[0])) || (r_fill[1] < $past(r_fill[1])) || (r_fill[2] < $past(r_fill[2])), "misaligned pass dropped no head")
    `TSA_ASSERT_NOW(a_ovf_sticky, 1'b1, !$fell(r_ovf), "overflow flag cleared outside reset")

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triaxial sample aligner testbench
// Feeds tagged samples through the sample channel and scores every aligned
// triple against a behavioural predictor of the per-axis queues. The
// tolerance register is rewritten between phases while the block is quiet.
// Both channel ends idle and stall at random.
// ----------------------------------------------------------------------------
module tb
    import tsa_pkg::*;
;

    localparam int QUEUE_DEPTH    = 64;
    localparam int SETTLE_CYCLES  = 1300;   // outlasts the longest run of drop-only passes
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [TIME_W-1:0] TIME_TOP = '1;

    typedef struct {
        logic [CODE_W-1:0]       code;
        logic [TIME_W-1:0]       time_ms;
        logic signed [SMP_W-1:0] sample;
        bit                      after_drain;
    } t_sample_beat;

    typedef struct {
        logic [TIME_W-1:0]       time_ms;
        logic signed [SMP_W-1:0] sample;
    } t_lane_entry;

    typedef struct {
        logic [TIME_W-1:0]       time_ms;
        logic signed [SMP_W-1:0] x;
        logic signed [SMP_W-1:0] y;
        logic signed [SMP_W-1:0] z;
        logic [SEQ_W-1:0]        seq;
        logic                    ovf;
    } t_triple;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tsa_sample_if smp_if ();
    tsa_cfg_if    cfg_if ();
    tsa_triple_if trp_if ();

    triaxial_sample_aligner #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (smp_if),
        .i_cfg_ch    (cfg_if),
        .o_triple_ch (trp_if)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    t_lane_entry      lane_fifo [NUM_AXES][$];
    logic [TOL_W-1:0] tol_cur;
    logic [SEQ_W-1:0] triple_seq;
    logic             lost_sample_flag;

    t_sample_beat pending_beats [$];
    t_triple      triples_due [$];
    bit           drained;
    int           idle_cycles;
    int           src_gap;
    int           sink_hold;
    bit           src_calm;
    bit           sink_calm;

    int fault_count;
    int beats_taken;
    int codes_ignored;
    int triples_checked;
    int tol_settings;

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------
    function automatic t_axis lane_of(input logic [CODE_W-1:0] code);
        case (code)
            "E", "e", "X", "x", "1": return AXIS_X;
            "N", "n", "Y", "y", "2": return AXIS_Y;
            "Z", "z", "3":           return AXIS_Z;
            default:                 return AXIS_NONE;
        endcase
    endfunction

    function automatic logic [CODE_W-1:0] code_for(input t_axis ax, input int k);
        logic [CODE_W-1:0] c;
        case (ax)
            AXIS_X: case (k % 5)
                0: c = "E"; 1: c = "e"; 2: c = "X"; 3: c = "x"; default: c = "1";
            endcase
            AXIS_Y: case (k % 5)
                0: c = "N"; 1: c = "n"; 2: c = "Y"; 3: c = "y"; default: c = "2";
            endcase
            default: case (k % 3)
                0: c = "Z"; 1: c = "z"; default: c = "3";
            endcase
        endcase
        return c;
    endfunction

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // queue the beat, then run the alignment loop; at most one triple per beat
    function automatic bit predict_alignment(input t_sample_beat beat, output t_triple tr);
        t_axis            ax;
        logic [TIME_W-1:0] head_t [NUM_AXES];
        logic [TIME_W-1:0] t_lo;
        logic [TIME_W-1:0] t_hi;
        logic [63:0]       tol64;
        ax    = lane_of(beat.code);
        tol64 = 64'(tol_cur);
        if (ax == AXIS_NONE) begin
            codes_ignored++;
        end else if (lane_fifo[ax].size() >= QUEUE_DEPTH) begin
            lost_sample_flag = 1'b1;
        end else begin
            lane_fifo[ax].push_back('{beat.time_ms, beat.sample});
        end
        while (lane_fifo[0].size() != 0 && lane_fifo[1].size() != 0 &&
               lane_fifo[2].size() != 0) begin
            for (int k = 0; k < NUM_AXES; k++) head_t[k] = lane_fifo[k][0].time_ms;
            t_lo = head_t[0];
            t_hi = head_t[0];
            for (int k = 1; k < NUM_AXES; k++) begin
                if (head_t[k] < t_lo) t_lo = head_t[k];
                if (head_t[k] > t_hi) t_hi = head_t[k];
            end
            if ((64'(t_hi - t_lo) << TOL_FRAC) > tol64) begin
                // drop every head too far behind the newest one
                for (int k = 0; k < NUM_AXES; k++)
                    if ((64'(t_hi - head_t[k]) << TOL_FRAC) > tol64)
                        lane_fifo[k].delete(0);
            end else begin
                triple_seq++;
                tr.time_ms = head_t[AXIS_X];
                tr.x       = lane_fifo[AXIS_X][0].sample;
                tr.y       = lane_fifo[AXIS_Y][0].sample;
                tr.z       = lane_fifo[AXIS_Z][0].sample;
                tr.seq     = triple_seq;
                tr.ovf     = lost_sample_flag;
                for (int k = 0; k < NUM_AXES; k++) lane_fifo[k].delete(0);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) $display("%s", msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
            note_fault($sformatf("triple %0d: %s expected %h got %h",
                                 triples_checked, name, want, got));
    endtask

    task automatic push_beat(input logic [CODE_W-1:0] code, input logic [TIME_W-1:0] t,
                             input logic signed [SMP_W-1:0] s, input bit after_drain);
        pending_beats.push_back('{code, t, s, after_drain});
    endtask

    // wait for the sender to empty, the triples to arrive and any drop pass to end
    task automatic settle();
        do @(negedge i_clk);
        while (pending_beats.size() != 0 || smp_if.valid || !drained);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] v);
        @(posedge i_clk);
        cfg_if.valid        <= 1'b1;
        cfg_if.tolerance_q8 <= v;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        tol_cur = v;
        tol_settings++;
    endtask

    // fill one axis past its depth, then let the other two catch up
    task automatic overflow_burst();
        logic [TIME_W-1:0] t0;
        t0 = {16'($urandom), 32'($urandom)};
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
            push_beat("x", t0 + TIME_W'(4 * i), $urandom, i == 0);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            push_beat("y", t0 + TIME_W'(4 * i), $urandom, 1'b0);
            push_beat("Z", t0 + TIME_W'(4 * i), $urandom, 1'b0);
        end
    endtask

    // mostly X/Y/Z groups around a moving time base, some lost samples and noise
    task automatic random_traffic(input int n_items);
        logic [TIME_W-1:0] base;
        t_axis             order [NUM_AXES];
        t_axis             swap;
        int                made;
        int                jmax;
        int                k;
        base = {16'($urandom), 32'($urandom)};
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(0, 99) < 10) begin
                push_beat(CODE_W'($urandom_range(0, 255)), {16'($urandom), 32'($urandom)},
                          $urandom, made == n_items / 2);
                made++;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: jmax = 2;
                    4, 5, 6:    jmax = 6;
                    7, 8:       jmax = 40;
                    default:    jmax = 3000;
                endcase
                order = '{AXIS_X, AXIS_Y, AXIS_Z};
                for (int j = NUM_AXES - 1; j > 0; j--) begin
                    k        = $urandom_range(0, j);
                    swap     = order[j];
                    order[j] = order[k];
                    order[k] = swap;
                end
                for (int j = 0; j < NUM_AXES; j++) begin
                    if ($urandom_range(0, 99) < 6) continue;
                    push_beat(code_for(order[j], $urandom_range(0, 4)),
                              base + TIME_W'($urandom_range(0, jmax)), $urandom,
                              made == n_items / 2);
                    made++;
                end
                base += TIME_W'($urandom_range(1, 12));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sample driver: take beats from the pending queue, with random gaps
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_sample_beat nb;
        if (!i_rst_n) begin
            smp_if.valid <= 1'b0;
            src_gap      <= 0;
        end else if (!smp_if.valid || smp_if.ready) begin
            if (src_gap != 0) begin
                src_gap      <= src_gap - 1;
                smp_if.valid <= 1'b0;
            end else if (pending_beats.size() == 0 ||
                         (pending_beats[0].after_drain && (smp_if.valid || !drained))) begin
                smp_if.valid <= 1'b0;
            end else begin
                nb = pending_beats[0];
                pending_beats.delete(0);
                smp_if.valid        <= 1'b1;
                smp_if.channel_code <= nb.code;
                smp_if.time_ms      <= nb.time_ms;
                smp_if.sample       <= nb.sample;
                src_gap             <= pick_gap(src_calm);
                if ($urandom_range(0, 49) == 0) src_calm <= !src_calm;
            end
        end
    end

    // ------------------------------------------------------------------------
    // triple sink: random stalls on ready
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        int stall;
        if (!i_rst_n) begin
            trp_if.ready <= 1'b0;
            sink_hold    <= 0;
        end else if (sink_hold != 0) begin
            sink_hold    <= sink_hold - 1;
            trp_if.ready <= 1'b0;
        end else begin
            stall = pick_gap(sink_calm);
            sink_hold    <= (stall > 0) ? stall - 1 : 0;
            trp_if.ready <= (stall == 0);
            if ($urandom_range(0, 99) == 0) sink_calm <= !sink_calm;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predict on each sample beat, score each triple beat
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_sample_beat sb;
        t_triple      fresh;
        t_triple      want;
        if (!i_rst_n) begin
            drained     <= 1'b1;
            idle_cycles <= 0;
        end else begin
            if (smp_if.valid && smp_if.ready) begin
                sb = '{smp_if.channel_code, smp_if.time_ms, smp_if.sample, 1'b0};
                beats_taken++;
                if (predict_alignment(sb, fresh)) triples_due.push_back(fresh);
            end
            if (trp_if.valid && trp_if.ready) begin
                triples_checked++;
                if (triples_due.size() == 0) begin
                    note_fault($sformatf("triple %0d unexpected: time %h seq %h",
                                         triples_checked, trp_if.triple_time_ms,
                                         trp_if.sequence_res));
                end else begin
                    want = triples_due[0];
                    triples_due.delete(0);
                    check_field("triple_time_ms", want.time_ms, trp_if.triple_time_ms);
                    check_field("x_sample", want.x, trp_if.x_sample);
                    check_field("y_sample", want.y, trp_if.y_sample);
                    check_field("z_sample", want.z, trp_if.z_sample);
                    check_field("sequence_res", want.seq, trp_if.sequence_res);
                    check_field("overflowed", want.ovf, trp_if.overflowed);
                end
            end
            if ((smp_if.valid && smp_if.ready) || (trp_if.valid && trp_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            drained <= (triples_due.size() == 0);
        end
    end

    // watchdog: give up when no beat moves for too long
    initial begin
        do @(posedge i_clk);
        while (idle_cycles < WATCHDOG_LIMIT);
        $display("watchdog: no beat for %0d cycles, %0d triples outstanding",
                 idle_cycles, triples_due.size());
        $display("tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n             = 1'b0;
        smp_if.valid        = 1'b0;
        smp_if.channel_code = '0;
        smp_if.time_ms      = '0;
        smp_if.sample       = '0;
        trp_if.ready        = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.tolerance_q8 = TOL_RESET;
        tol_cur             = TOL_RESET;
        triple_seq          = '0;
        lost_sample_flag    = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset tolerance: field extremes, every code, drops and realignment
        push_beat("X", 48'd0, 32'sh7FFF_FFFF, 1'b0);
        push_beat("n", 48'd1, -32'sd1, 1'b0);
        push_beat("3", 48'd2, 32'sd0, 1'b0);
        push_beat(8'h00, 48'd5, 32'sd7, 1'b0);
        push_beat(8'hFF, 48'd6, 32'sd8, 1'b0);
        push_beat("e", TIME_TOP, 32'sh8000_0000, 1'b0);
        push_beat("Y", TIME_TOP - 48'd2, 32'sd1, 1'b0);
        push_beat("z", TIME_TOP, -32'sd2, 1'b0);
        push_beat("x", 48'd100, 32'sd10, 1'b0);
        push_beat("y", 48'd200, 32'sd11, 1'b0);
        push_beat("Z", 48'd103, 32'sd12, 1'b0);
        push_beat("1", 48'd199, 32'sd13, 1'b0);
        push_beat("3", 48'd201, 32'sd14, 1'b0);
        push_beat("E", 48'd300, 32'sd15, 1'b0);
        push_beat("N", 48'd303, 32'sd16, 1'b0);
        push_beat("z", 48'd302, 32'sd17, 1'b0);
        push_beat("X", 48'd302, 32'sd18, 1'b0);
        push_beat("2", 48'd400, 32'sd19, 1'b0);
        push_beat("Z", 48'd400, 32'sd20, 1'b0);
        push_beat("x", 48'd400, 32'sd21, 1'b0);
        settle();

        // zero tolerance: only equal heads pair up
        write_tolerance('0);
        push_beat("X", 48'd5, 32'sd1, 1'b0);
        push_beat("Y", 48'd5, 32'sd2, 1'b0);
        push_beat("Z", 48'd5, 32'sd3, 1'b0);
        push_beat("X", 48'd6, 32'sd4, 1'b0);
        push_beat("Y", 48'd7, 32'sd5, 1'b0);
        push_beat("Z", 48'd6, 32'sd6, 1'b0);
        push_beat("X", 48'd7, 32'sd7, 1'b0);
        push_beat("Z", 48'd7, 32'sd8, 1'b0);
        settle();

        write_tolerance(24'd640);
        overflow_burst();
        random_traffic(110);
        settle();

        write_tolerance(24'hFF_FFFF);
        random_traffic(110);
        settle();

        write_tolerance(TOL_W'($urandom_range(0, 4095)));
        random_traffic(120);
        settle();

        write_tolerance(TOL_W'($urandom));
        random_traffic(60);
        settle();

        write_tolerance(24'd256);
        random_traffic(100);
        settle();

        if (triples_due.size() != 0)
            note_fault($sformatf("%0d triples never arrived", triples_due.size()));
        $display("run covered %0d sample beats (%0d with unknown codes) under %0d tolerance writes",
                 beats_taken, codes_ignored, tol_settings);
        $display("%0d triples scored, %0d faults, queue overflow reached: %0d",
                 triples_checked, fault_count, lost_sample_flag);
        if (fault_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
